@@ rtl/rbsi_pkg.sv @@
// rbsi_pkg: shared constants for the ray/box slab intersection core
// no dependencies; imported by the interfaces and the core

package rbsi_pkg;

  localparam int RBSI_COORD_WIDTH = 32;
  localparam int ROOT_FRAC        = 16;
  localparam int T_WIDTH          = 64;

  // internal distance clamp, 2^62 raw
  localparam logic signed [T_WIDTH-1:0] T_MAX     = 64'sh4000_0000_0000_0000;
  localparam logic signed [T_WIDTH-1:0] T_NEG_MAX = -64'sh4000_0000_0000_0000;

endpackage

@@ rtl/rbsi_if.sv @@
// rbsi_in_if / rbsi_out_if: valid/ready channels of the intersection core
// depends on rbsi_pkg for the default coordinate width

interface rbsi_in_if import rbsi_pkg::*; #(
  parameter int CW = RBSI_COORD_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] origin_x;
  logic signed [CW-1:0] origin_y;
  logic signed [CW-1:0] origin_z;
  logic signed [CW-1:0] target_x;
  logic signed [CW-1:0] target_y;
  logic signed [CW-1:0] target_z;
  logic signed [CW-1:0] box_min_x;
  logic signed [CW-1:0] box_min_y;
  logic signed [CW-1:0] box_min_z;
  logic signed [CW-1:0] box_max_x;
  logic signed [CW-1:0] box_max_y;
  logic signed [CW-1:0] box_max_z;

  modport source (
    output valid, origin_x, origin_y, origin_z, target_x, target_y, target_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, target_x, target_y, target_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

interface rbsi_out_if import rbsi_pkg::*; #(
  parameter int CW = RBSI_COORD_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic signed [CW-1:0] entry_distance;

  modport source (output valid, hit, entry_distance, input ready);
  modport sink   (input valid, hit, entry_distance, output ready);
endinterface

@@ rtl/ray_box_slab_intersect_core.sv @@
// ray_box_slab_intersect_core: ray against axis-aligned box, slab test
// one beat per cycle while no result beat waits at the output
// depth set by the bit-per-stage square root and the six slab dividers
// the whole pipeline stalls only while a result beat waits at the output
// rst_n synchronous: clears all valid bits, data registers are not reset
// depends on rbsi_pkg, rbsi_if, rbsi_div

module ray_box_slab_intersect_core import rbsi_pkg::*; #(
  parameter int COORD_WIDTH = RBSI_COORD_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  rbsi_in_if.sink     in_ch,
  rbsi_out_if.source  out_ch
);

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;
  localparam int SW  = 2 * CW + 2;
  localparam int S2W = SW + 2 * ROOT_FRAC;
  localparam int RW  = CW + ROOT_FRAC + 1;
  localparam int RH  = (RW + 1) / 2;
  localparam int RU  = RW - RH;
  localparam int NW  = CW + RW;
  localparam int DVW = CW + ROOT_FRAC;
  localparam int QW  = NW - ROOT_FRAC;
  localparam int QXW = (QW > T_WIDTH - 1) ? QW : T_WIDTH - 1;
  localparam int TW  = T_WIDTH;

  localparam logic signed [TW-1:0] LIM_HI = (TW'(1) << (CW - 1)) - TW'(1);
  localparam logic signed [TW-1:0] LIM_LO = ~LIM_HI;

  typedef struct packed {
    logic [2:0][CW-1:0] dmag;
    logic [2:0][CW-1:0] lmag;
    logic [2:0][CW-1:0] hmag;
    logic [2:0]         dneg;
    logic [2:0]         lneg;
    logic [2:0]         hneg;
    logic [2:0]         dzero;
    logic               zmiss;
  } sb_t;

  function automatic logic [CW-1:0] mag(input logic signed [DW-1:0] x);
    mag = x[DW-1] ? CW'(-x) : CW'(x);
  endfunction

  logic en;
  logic out_valid_r;
  logic hit_r;
  logic signed [CW-1:0] dist_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // input unpacking
  logic signed [CW-1:0] o_w [3];
  logic signed [CW-1:0] t_w [3];
  logic signed [CW-1:0] lo_w [3];
  logic signed [CW-1:0] hi_w [3];

  assign o_w[0]  = in_ch.origin_x;
  assign o_w[1]  = in_ch.origin_y;
  assign o_w[2]  = in_ch.origin_z;
  assign t_w[0]  = in_ch.target_x;
  assign t_w[1]  = in_ch.target_y;
  assign t_w[2]  = in_ch.target_z;
  assign lo_w[0] = in_ch.box_min_x;
  assign lo_w[1] = in_ch.box_min_y;
  assign lo_w[2] = in_ch.box_min_z;
  assign hi_w[0] = in_ch.box_max_x;
  assign hi_w[1] = in_ch.box_max_y;
  assign hi_w[2] = in_ch.box_max_z;

  // stage 1: differences and the zero-direction miss flag
  logic                 v1_r;
  logic signed [DW-1:0] d1_r  [3];
  logic signed [DW-1:0] nl1_r [3];
  logic signed [DW-1:0] nh1_r [3];
  logic                 zmiss1_r;
  logic                 zmiss1_nxt;

  always_comb begin
    zmiss1_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if ((t_w[i] == o_w[i]) && ((o_w[i] > hi_w[i]) || (o_w[i] < lo_w[i]))) begin
        zmiss1_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i]  <= DW'(t_w[i])  - DW'(o_w[i]);
        nl1_r[i] <= DW'(lo_w[i]) - DW'(o_w[i]);
        nh1_r[i] <= DW'(hi_w[i]) - DW'(o_w[i]);
      end
      zmiss1_r <= zmiss1_nxt;
    end
  end

  // stage 2: magnitudes and signs
  logic v2_r;
  sb_t  sb2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sb2_r.dmag[i]  <= mag(d1_r[i]);
        sb2_r.lmag[i]  <= mag(nl1_r[i]);
        sb2_r.hmag[i]  <= mag(nh1_r[i]);
        sb2_r.dneg[i]  <= d1_r[i][DW-1];
        sb2_r.lneg[i]  <= nl1_r[i][DW-1];
        sb2_r.hneg[i]  <= nh1_r[i][DW-1];
        sb2_r.dzero[i] <= (d1_r[i] == '0);
      end
      sb2_r.zmiss <= zmiss1_r;
    end
  end

  // stage 3: squares
  logic            v3_r;
  sb_t             sb3_r;
  logic [2*CW-1:0] sq3_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq3_r[i] <= (2 * CW)'(sb2_r.dmag[i]) * (2 * CW)'(sb2_r.dmag[i]);
      end
      sb3_r <= sb2_r;
    end
  end

  // stage 4: sum of squares
  logic          v4_r;
  sb_t           sb4_r;
  logic [SW-1:0] s4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r  <= SW'(sq3_r[0]) + SW'(sq3_r[1]) + SW'(sq3_r[2]);
      sb4_r <= sb3_r;
    end
  end

  // square root, one root bit per stage
  logic           vq_r    [RW];
  sb_t            sbq_r   [RW];
  logic [RW-1:0]  root_r  [RW];
  logic [S2W-1:0] qrem_r  [RW-1];

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int B = RW - 1 - k;
    logic [S2W-1:0] rem_in;
    logic [RW-1:0]  root_in;
    sb_t            sb_in;
    logic [S2W-1:0] trial;
    logic           take;

    if (k == 0) begin : g_first
      assign rem_in  = {s4_r, (2 * ROOT_FRAC)'(0)};
      assign root_in = '0;
      assign sb_in   = sb4_r;
    end else begin : g_next
      assign rem_in  = qrem_r[k-1];
      assign root_in = root_r[k-1];
      assign sb_in   = sbq_r[k-1];
    end

    assign trial = (S2W'(root_in) << (B + 1)) | (S2W'(1) << (2 * B));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= take ? (root_in | (RW'(1) << B)) : root_in;
        sbq_r[k]  <= sb_in;
      end
    end

    if (k < RW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          qrem_r[k] <= take ? (rem_in - trial) : rem_in;
        end
      end
    end
  end

  // numerator times length, split in two partial products
  logic             vm1_r;
  logic             vm2_r;
  sb_t              sbm1_r;
  sb_t              sbm2_r;
  logic [CW+RH-1:0] pl_r [6];
  logic [CW+RU-1:0] pu_r [6];
  logic [NW-1:0]    n_r  [6];
  logic [QW-1:0]    q_w  [6];

  logic           vd_r  [QW];
  sb_t            sbd_r [QW];

  for (genvar j = 0; j < 6; j++) begin : g_slab
    localparam int AX = j % 3;
    localparam int HI = j / 3;
    logic [CW-1:0] num_mag;

    assign num_mag = (HI != 0) ? sbq_r[RW-1].hmag[AX] : sbq_r[RW-1].lmag[AX];

    always_ff @(posedge clk) begin
      if (en) begin
        pl_r[j] <= (CW + RH)'(num_mag) * (CW + RH)'(root_r[RW-1][RH-1:0]);
        pu_r[j] <= (CW + RU)'(num_mag) * (CW + RU)'(root_r[RW-1][RW-1:RH]);
        n_r[j]  <= (NW'(pu_r[j]) << RH) + NW'(pl_r[j]);
      end
    end

    rbsi_div #(
      .NW  (NW),
      .DVW (DVW),
      .QW  (QW)
    ) u_div (
      .clk (clk),
      .en  (en),
      .n   (n_r[j]),
      .dv  ({sbm2_r.dmag[AX], ROOT_FRAC'(0)}),
      .q   (q_w[j])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbm1_r <= sbq_r[RW-1];
      sbm2_r <= sbm1_r;
      sbd_r[0] <= sbm2_r;
      for (int k = 1; k < QW; k++) begin
        sbd_r[k] <= sbd_r[k-1];
      end
    end
  end

  // c1: clamp and sign the slab distances
  logic                 vc1_r;
  sb_t                  sbc1_r;
  logic signed [TW-1:0] t1_r [6];

  for (genvar j = 0; j < 6; j++) begin : g_sign
    localparam int AX = j % 3;
    localparam int HI = j / 3;
    logic [QXW-1:0]       qx;
    logic [TW-2:0]        qmag;
    logic signed [TW-1:0] tpos;
    logic                 neg;

    assign qx   = QXW'(q_w[j]);
    assign qmag = (qx > QXW'(T_MAX)) ? (TW - 1)'(T_MAX) : qx[TW-2:0];
    assign tpos = $signed({1'b0, qmag});
    assign neg  = ((HI != 0) ? sbd_r[QW-1].hneg[AX] : sbd_r[QW-1].lneg[AX])
                  ^ sbd_r[QW-1].dneg[AX];

    always_ff @(posedge clk) begin
      if (en) begin
        t1_r[j] <= neg ? -tpos : tpos;
      end
    end
  end

  // c2: sort each slab
  logic                 vc2_r;
  sb_t                  sbc2_r;
  logic signed [TW-1:0] tlo2_r [3];
  logic signed [TW-1:0] thi2_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      sbc1_r <= sbd_r[QW-1];
      sbc2_r <= sbc1_r;
      for (int i = 0; i < 3; i++) begin
        if (t1_r[i] > t1_r[i+3]) begin
          tlo2_r[i] <= t1_r[i+3];
          thi2_r[i] <= t1_r[i];
        end else begin
          tlo2_r[i] <= t1_r[i];
          thi2_r[i] <= t1_r[i+3];
        end
      end
    end
  end

  // c3: clip by x and y
  logic                 vc3_r;
  sb_t                  sbc3_r;
  logic signed [TW-1:0] tn3_r, tf3_r, tlz3_r, thz3_r;
  logic signed [TW-1:0] tn3_nxt, tf3_nxt, tn_a, tf_a;

  always_comb begin
    tn_a = sbc2_r.dzero[0] ? T_NEG_MAX : tlo2_r[0];
    tf_a = sbc2_r.dzero[0] ? T_MAX     : thi2_r[0];
    if (sbc2_r.dzero[1]) begin
      tn3_nxt = tn_a;
      tf3_nxt = tf_a;
    end else if (sbc2_r.dzero[0]) begin
      tn3_nxt = tlo2_r[1];
      tf3_nxt = thi2_r[1];
    end else begin
      tn3_nxt = (tlo2_r[1] > tlo2_r[0]) ? tlo2_r[1] : tlo2_r[0];
      tf3_nxt = (thi2_r[1] < thi2_r[0]) ? thi2_r[1] : thi2_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbc3_r <= sbc2_r;
      tn3_r  <= tn3_nxt;
      tf3_r  <= tf3_nxt;
      tlz3_r <= tlo2_r[2];
      thz3_r <= thi2_r[2];
    end
  end

  // c4: early rejection after y
  logic                 vc4_r;
  sb_t                  sbc4_r;
  logic                 early4_r;
  logic signed [TW-1:0] tn4_r, tf4_r, tlz4_r, thz4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sbc4_r   <= sbc3_r;
      early4_r <= (tn3_r > tf3_r) || tf3_r[TW-1];
      tn4_r    <= tn3_r;
      tf4_r    <= tf3_r;
      tlz4_r   <= tlz3_r;
      thz4_r   <= thz3_r;
    end
  end

  // c5: clip by z
  logic                 vc5_r;
  sb_t                  sbc5_r;
  logic                 early5_r;
  logic signed [TW-1:0] tn5_r, tf5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sbc5_r   <= sbc4_r;
      early5_r <= early4_r;
      if (sbc4_r.dzero[2]) begin
        tn5_r <= tn4_r;
        tf5_r <= tf4_r;
      end else begin
        tn5_r <= (tlz4_r > tn4_r) ? tlz4_r : tn4_r;
        tf5_r <= (thz4_r < tf4_r) ? thz4_r : tf4_r;
      end
    end
  end

  // output register: final rejection and saturation
  logic                 miss_w;
  logic signed [TW-1:0] tsat_w;

  assign miss_w = early5_r || sbc5_r.zmiss || (&sbc5_r.dzero) ||
                  (tn5_r > tf5_r) || (tf5_r <= 0);

  always_comb begin
    priority if (tn5_r > LIM_HI) begin
      tsat_w = LIM_HI;
    end else if (tn5_r < LIM_LO) begin
      tsat_w = LIM_LO;
    end else begin
      tsat_w = tn5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= !miss_w;
      dist_r <= miss_w ? '0 : tsat_w[CW-1:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      vm1_r       <= 1'b0;
      vm2_r       <= 1'b0;
      vc1_r       <= 1'b0;
      vc2_r       <= 1'b0;
      vc3_r       <= 1'b0;
      vc4_r       <= 1'b0;
      vc5_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < RW; k++) vq_r[k] <= 1'b0;
      for (int k = 0; k < QW; k++) vd_r[k] <= 1'b0;
    end else if (en) begin
      v1_r     <= in_ch.valid;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      v4_r     <= v3_r;
      vq_r[0]  <= v4_r;
      for (int k = 1; k < RW; k++) vq_r[k] <= vq_r[k-1];
      vm1_r    <= vq_r[RW-1];
      vm2_r    <= vm1_r;
      vd_r[0]  <= vm2_r;
      for (int k = 1; k < QW; k++) vd_r[k] <= vd_r[k-1];
      vc1_r       <= vd_r[QW-1];
      vc2_r       <= vc1_r;
      vc3_r       <= vc2_r;
      vc4_r       <= vc3_r;
      vc5_r       <= vc4_r;
      out_valid_r <= vc5_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.hit            = hit_r;
  assign out_ch.entry_distance = dist_r;

endmodule

@@ rtl/rbsi_div.sv @@
// rbsi_div: pipelined restoring divider, one quotient bit per stage
// no package dependency; advances on en

module rbsi_div #(
  parameter int NW  = 81,
  parameter int DVW = 48,
  parameter int QW  = 65
) (
  input  logic           clk,
  input  logic           en,
  input  logic [NW-1:0]  n,
  input  logic [DVW-1:0] dv,
  output logic [QW-1:0]  q
);

  localparam int EW = (NW > DVW + QW) ? NW : DVW + QW;

  logic [NW-1:0]  rem_r [QW-1];
  logic [DVW-1:0] dv_r  [QW-1];
  logic [QW-1:0]  q_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int J = QW - 1 - k;
    logic [NW-1:0]  rem_in;
    logic [DVW-1:0] dv_in;
    logic [QW-1:0]  q_in;
    logic [EW-1:0]  trial;
    logic [EW-1:0]  diff;
    logic           take;

    if (k == 0) begin : g_first
      assign rem_in = n;
      assign dv_in  = dv;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dv_in  = dv_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign trial = EW'(dv_in) << J;
    assign take  = EW'(rem_in) >= trial;
    assign diff  = EW'(rem_in) - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= take ? (q_in | (QW'(1) << J)) : q_in;
      end
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? diff[NW-1:0] : rem_in;
          dv_r[k]  <= dv_in;
        end
      end
    end
  end

  assign q = q_r[QW-1];

endmodule

@@ rtl/rbsi_checker.sv @@
// rbsi_checker: port-level checks of the intersection core, bound to the top
// no package dependency; sees only the channel signals

module rbsi_checker #(
  parameter int CW = 32
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic          out_hit,
  input logic [CW-1:0] out_entry_distance
);

  // empty output slot means the pipeline is taking beats
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready while output slot empty");

  // a waiting result stalls the whole pipeline
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result beat stalled");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_hit) && $stable(out_entry_distance)))
    else $error("stalled result beat changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_entry_distance == '0))
    else $error("miss with nonzero entry distance");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

endmodule

bind ray_box_slab_intersect_core rbsi_checker #(
  .CW (COORD_WIDTH)
) u_rbsi_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_hit            (out_ch.hit),
  .out_entry_distance (out_ch.entry_distance)
);

@@ tb/rbsi_check.sv @@
// rbsi_check: watches both channels of the slab intersection core, predicts each result
// from the input beat in fixed point and compares hit and entry distance in order
// depends on rbsi_pkg and rbsi_if

module rbsi_check import rbsi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rbsi_in_if         in_ch,
  rbsi_out_if        out_ch,
  output int         fail_count,
  output int         pending,
  output int         hit_count,
  output int         miss_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              hit;
    logic signed [31:0] distance;
  } slab_result_t;

  slab_result_t expected_q[$];

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] wide_isqrt(input logic [127:0] s);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] slab_dist(input logic signed [63:0] num,
                                                   input logic signed [63:0] den,
                                                   input logic [63:0] len);
    logic [127:0] n;
    logic [127:0] q;
    logic [63:0]  qq;
    n = {64'd0, mag64(num)} * {64'd0, len};
    q = n / ({64'd0, mag64(den)} << ROOT_FRAC);
    qq = (q > 128'(T_MAX)) ? 64'(T_MAX) : q[63:0];
    return ((num < 0) != (den < 0)) ? -$signed(qq) : $signed(qq);
  endfunction

  function automatic slab_result_t predict_hit(
      input logic signed [31:0] o[3], input logic signed [31:0] tg[3],
      input logic signed [31:0] lo[3], input logic signed [31:0] hi[3]);
    logic signed [63:0] d[3];
    logic signed [63:0] tn, tf, t1, t2, x;
    logic [127:0] s;
    logic [63:0] len;
    slab_result_t r;
    r = '0;
    s = '0;
    tn = T_NEG_MAX;
    tf = T_MAX;
    for (int i = 0; i < 3; i++) begin
      d[i] = 64'(tg[i]) - 64'(o[i]);
      s += {64'd0, mag64(d[i])} * {64'd0, mag64(d[i])};
    end
    if (s == 0) return r;
    len = wide_isqrt(s << (2 * ROOT_FRAC));
    for (int i = 0; i < 3; i++) begin
      if (d[i] == 0) begin
        if (o[i] > hi[i] || o[i] < lo[i]) return r;
      end else begin
        t1 = slab_dist(64'(lo[i]) - 64'(o[i]), d[i], len);
        t2 = slab_dist(64'(hi[i]) - 64'(o[i]), d[i], len);
        if (t1 > t2) begin
          x = t1; t1 = t2; t2 = x;
        end
        if (t1 > tn) tn = t1;
        if (t2 < tf) tf = t2;
      end
      if (i == 1 && (tn > tf || tf < 0)) return r;
    end
    if (tn > tf || tf <= 0) return r;
    if (tn > 64'sd2147483647) tn = 64'sd2147483647;
    if (tn < -64'sd2147483648) tn = -64'sd2147483648;
    r.hit = 1'b1;
    r.distance = tn[31:0];
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    logic signed [31:0] o[3], tg[3], lo[3], hi[3];
    slab_result_t e;
    int errs;
    if (!rst_n) begin
      fail_count <= 0;
      hit_count  <= 0;
      miss_count <= 0;
      expected_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        o  = '{in_ch.origin_x, in_ch.origin_y, in_ch.origin_z};
        tg = '{in_ch.target_x, in_ch.target_y, in_ch.target_z};
        lo = '{in_ch.box_min_x, in_ch.box_min_y, in_ch.box_min_z};
        hi = '{in_ch.box_max_x, in_ch.box_max_y, in_ch.box_max_z};
        expected_q = {expected_q, predict_hit(o, tg, lo, hi)};
      end
      if (out_ch.valid && out_ch.ready) begin
        errs = 0;
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          errs = 1;
        end else begin
          e = expected_q.pop_front();
          if (e.hit) hit_count <= hit_count + 1;
          else miss_count <= miss_count + 1;
          if (out_ch.hit !== e.hit) begin
            $error("hit: expected %0b actual %0b", e.hit, out_ch.hit);
            errs++;
          end
          if (out_ch.entry_distance !== e.distance) begin
            $error("entry_distance: expected %0d actual %0d", e.distance,
                   out_ch.entry_distance);
            errs++;
          end
        end
        if (errs != 0) fail_count <= fail_count + errs;
      end
    end
  end
endmodule

@@ tb/tb_ray_box_slab_intersect_core.sv @@
// tb_ray_box_slab_intersect_core: directed and random rays against boxes
// with random idling on both sides; depends on rbsi_pkg, rbsi_if, rbsi_check and the core

module tb_ray_box_slab_intersect_core;
  timeunit 1ns;
  timeprecision 1ps;
  import rbsi_pkg::*;

  localparam int NUM_RANDOM = 1200;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending, hit_count, miss_count;
  int   idle_cycles = 0;
  int   beats_sent = 0;
  bit   calm_out = 1'b0;

  rbsi_in_if  in_ch ();
  rbsi_out_if out_ch ();

  ray_box_slab_intersect_core dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
  rbsi_check chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                  .fail_count(fail_count), .pending(pending),
                  .hit_count(hit_count), .miss_count(miss_count));

  always #4 clk = ~clk;

  function automatic logic [31:0] rnd_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 * 65536 * 40)) - 65536 * 40);
      2: return 32'($signed($urandom_range(0, 2 * 16)) - 16) << 16;
      default: return 32'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  task automatic send_ray(input logic [31:0] o[3], input logic [31:0] t[3],
                          input logic [31:0] lo[3], input logic [31:0] hi[3]);
    int gap;
    gap = calm_out ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.origin_x, in_ch.origin_y, in_ch.origin_z} <= {o[0], o[1], o[2]};
    {in_ch.target_x, in_ch.target_y, in_ch.target_z} <= {t[0], t[1], t[2]};
    {in_ch.box_min_x, in_ch.box_min_y, in_ch.box_min_z} <= {lo[0], lo[1], lo[2]};
    {in_ch.box_max_x, in_ch.box_max_y, in_ch.box_max_z} <= {hi[0], hi[1], hi[2]};
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    @(negedge clk);
  endtask

  // random ray and box, the box sometimes inverted, the ray sometimes degenerate
  task automatic random_ray();
    logic [31:0] o[3], t[3], lo[3], hi[3], a, b;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      o[i] = rnd_coord(mode < 2 ? 0 : mode % 4);
      t[i] = ($urandom_range(0, 5) == 0) ? o[i] : rnd_coord(mode < 2 ? 0 : mode % 4);
      a = rnd_coord(mode < 1 ? 0 : mode % 4);
      b = rnd_coord(mode < 1 ? 0 : mode % 4);
      if ($urandom_range(0, 7) != 0 && $signed(a) > $signed(b)) begin
        lo[i] = b; hi[i] = a;
      end else begin
        lo[i] = a; hi[i] = b;
      end
    end
    send_ray(o, t, lo, hi);
  endtask

  initial begin
    logic [31:0] z[3], one[3], mx[3], mn[3], nb[3], pb[3], xa[3];
    in_ch.valid = 1'b0;
    {in_ch.origin_x, in_ch.origin_y, in_ch.origin_z} = '0;
    {in_ch.target_x, in_ch.target_y, in_ch.target_z} = '0;
    {in_ch.box_min_x, in_ch.box_min_y, in_ch.box_min_z} = '0;
    {in_ch.box_max_x, in_ch.box_max_y, in_ch.box_max_z} = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    z   = '{0, 0, 0};
    one = '{32'h10000, 32'h10000, 32'h10000};
    mx  = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    mn  = '{32'h80000000, 32'h80000000, 32'h80000000};
    nb  = '{32'hfffe0000, 32'hfffe0000, 32'hfffe0000};
    pb  = '{32'h20000, 32'h20000, 32'h20000};
    xa  = '{32'h10000, 0, 0};
    send_ray(z, z, nb, pb);                           // coincident points
    send_ray(z, xa, nb, pb);                          // origin inside box
    send_ray(nb, one, z, one);                        // entry ahead
    send_ray(one, pb, nb, z);                         // box behind ray
    send_ray(z, xa, '{32'hfffe0000, 32'h30000, 0}, '{32'h20000, 32'h40000, 32'h10000});
    send_ray(z, xa, '{32'hfffe0000, 0, 0}, '{32'h20000, 32'h10000, 32'h10000});
    send_ray(z, xa, pb, nb);                          // inverted box
    send_ray(mn, mx, mn, mx);                         // extreme coordinates
    send_ray(mx, mn, mn, mx);
    send_ray(mn, '{32'h80000001, 32'h80000000, 32'h80000000}, mx, mx);
    send_ray(mx, '{32'h7ffffffe, 32'h7fffffff, 32'h7fffffff}, mn, mn);
    send_ray(z, '{1, 0, 0}, '{32'h7ffffff0, 32'h80000000, 32'h80000000}, mx);
    send_ray(z, '{1, 0, 0}, '{32'h80000000, 32'h80000000, 32'h80000000},
             '{32'h80000010, 32'h7fffffff, 32'h7fffffff});
    send_ray(nb, '{32'hfffe0001, 32'hfffe0000, 32'hfffe0000}, '{0, nb[1], nb[2]},
             '{0, pb[1], pb[2]});                     // box flat in x, t_near equals t_far
    send_ray(z, xa, '{32'hfffe0000, 0, 32'hfffe0000}, '{0, 0, 0}); // touching faces
    send_ray(one, one, z, pb);
    repeat (NUM_RANDOM) random_ray();
    in_ch.valid <= 1'b0;
    calm_out = 1'b0;
  end

  // output side idling, drawn for every result beat
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, 19);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge rst_n);
    wait (beats_sent == NUM_RANDOM + 16 && pending == 0);
    repeat (200) @(posedge clk);
    $display("%0d rays sent, %0d hits and %0d misses checked", beats_sent, hit_count,
             miss_count);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/rbsi_pkg.sv
rtl/rbsi_if.sv
rtl/rbsi_div.sv
rtl/ray_box_slab_intersect_core.sv
rtl/rbsi_checker.sv
tb/rbsi_check.sv
tb/tb_ray_box_slab_intersect_core.sv
